// File: src/nearest_centroid_quantizer_3d_assert.svh
// Assertion macros used by the quantizer top level.
`ifndef NEAREST_CENTROID_QUANTIZER_3D_ASSERT_SVH
`define NEAREST_CENTROID_QUANTIZER_3D_ASSERT_SVH

// Same-cycle implication, off during reset.
`define NCQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define NCQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/ncq_pkg.sv
// Package: widths, centroid layout and compare helper for the quantizer.
package ncq_pkg;

  localparam int NUM_CENTROIDS = 14;
  localparam int NUM_AXES      = 3;
  localparam int NUM_COORDS    = 5;

  localparam int ACC_W  = 16;
  localparam int CFG_W  = 16;
  localparam int RAD_W  = ACC_W + 1;
  localparam int PROD_W = 34;
  localparam int DIFF_W = RAD_W + 1;
  localparam int SQ_W   = 2 * DIFF_W - 1;
  localparam int DIST_W = SQ_W + 1;
  localparam int IDX_W  = 4;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  // cos 45 degrees in Q0.16, and the rounding half for the >> 16
  localparam logic signed [RAD_W:0]    COS45_Q16  = 18'sd46341;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 34'sd32768;

  // Register indexes
  typedef enum logic [0:0] {
    REG_MAX_ACCEL = 1'b0,
    REG_MIN_ACCEL = 1'b1
  } cfg_reg_t;

  // Per-axis centroid coordinate: zero, +R, -R, +D, -D
  typedef enum logic [2:0] {
    AX_ZERO  = 3'd0,
    AX_POS_R = 3'd1,
    AX_NEG_R = 3'd2,
    AX_POS_D = 3'd3,
    AX_NEG_D = 3'd4
  } axis_code_t;

  localparam axis_code_t CENT_CODE [NUM_CENTROIDS][NUM_AXES] = '{
    '{AX_POS_R, AX_ZERO,  AX_ZERO },
    '{AX_POS_D, AX_ZERO,  AX_POS_D},
    '{AX_ZERO,  AX_ZERO,  AX_POS_R},
    '{AX_NEG_D, AX_ZERO,  AX_POS_D},
    '{AX_NEG_R, AX_ZERO,  AX_ZERO },
    '{AX_NEG_D, AX_ZERO,  AX_NEG_D},
    '{AX_ZERO,  AX_ZERO,  AX_NEG_R},
    '{AX_POS_D, AX_ZERO,  AX_NEG_D},
    '{AX_ZERO,  AX_POS_R, AX_ZERO },
    '{AX_ZERO,  AX_POS_D, AX_POS_D},
    '{AX_ZERO,  AX_NEG_D, AX_POS_D},
    '{AX_ZERO,  AX_NEG_R, AX_ZERO },
    '{AX_ZERO,  AX_NEG_D, AX_NEG_D},
    '{AX_ZERO,  AX_POS_D, AX_NEG_D}
  };

  // Pipeline control handed to the compare tree
  typedef struct packed {
    logic adv;
    logic valid;
  } pipe_ctrl_t;

  // One candidate: squared distance and centroid index
  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [IDX_W-1:0]  idx;
  } cand_t;

  // Keep the lower-index candidate a unless b is strictly closer
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t res;
    res = (b.sq_dist < a.sq_dist) ? b : a;
    return res;
  endfunction

endpackage

// File: src/ncq_argmin.sv
// Registered compare tree: 14 candidates down to the nearest index.
module ncq_argmin
  import ncq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  pipe_ctrl_t               ctrl,
  input  logic [DIST_W-1:0]        dist_in [NUM_CENTROIDS],
  output logic                     out_valid,
  output logic [IDX_W-1:0]         out_idx
);

  cand_t t1_cand [7];
  cand_t t2_cand [4];
  cand_t t3_cand [2];
  logic  t1_valid;
  logic  t2_valid;
  logic  t3_valid;
  cand_t leaf [NUM_CENTROIDS];

  // Tag each distance with its index
  always_comb begin
    for (int k = 0; k < NUM_CENTROIDS; k++) begin
      leaf[k].sq_dist = dist_in[k];
      leaf[k].idx     = IDX_W'(k);
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid  <= 1'b0;
      t2_valid  <= 1'b0;
      t3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (ctrl.adv) begin
      t1_valid  <= ctrl.valid;
      t2_valid  <= t1_valid;
      t3_valid  <= t2_valid;
      out_valid <= t3_valid;
    end
  end

  // Reduce 14 -> 7 -> 4 -> 2 -> 1, adjacent pairs so lower index wins ties
  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      for (int i = 0; i < 7; i++) begin
        t1_cand[i] <= pick(leaf[2*i], leaf[2*i+1]);
      end
      t2_cand[0] <= pick(t1_cand[0], t1_cand[1]);
      t2_cand[1] <= pick(t1_cand[2], t1_cand[3]);
      t2_cand[2] <= pick(t1_cand[4], t1_cand[5]);
      t2_cand[3] <= t1_cand[6];
      t3_cand[0] <= pick(t2_cand[0], t2_cand[1]);
      t3_cand[1] <= pick(t2_cand[2], t2_cand[3]);
      out_idx    <= pick(t3_cand[0], t3_cand[1]).idx;
    end
  end

endmodule

// File: src/nearest_centroid_quantizer_3d.sv
// Top level: nearest-centroid quantizer for 3-axis acceleration samples.
//
// Input beats on s_* carry one sample (accel_x, accel_y, accel_z, signed
// Q3.12). Output beats on m_* carry the index 0..13 of the nearest of 14
// centroids on a sphere of radius (max_accel + min_accel) / 2; the lowest
// index wins on equal distance.
// Registers are written through cfg_we / cfg_index / cfg_wdata: index 0 is
// max_accel, index 1 is min_accel, both reset to 1.0 (4096). Write them only
// while no sample is in flight.
// From input beat to output beat, six stages capture the sample and build the
// radius, diagonal, per-axis differences, squares and distances, and four
// stages of the compare tree pick the minimum.
// Throughput is one sample per cycle while m_* is not stalled; every stage is one register stage.
// When the receiver stalls with a beat held on m_*, the whole pipeline
// freezes and s_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and restores the registers.
module nearest_centroid_quantizer_3d
  import ncq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // config write port
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] accel_x, [31:16] accel_y, [47:32] accel_z
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [3:0] centroid_index, [7:4] zero
);

`include "nearest_centroid_quantizer_3d_assert.svh"

  logic signed [CFG_W-1:0]  max_accel;
  logic signed [CFG_W-1:0]  min_accel;

  logic                     adv;
  pipe_ctrl_t               tree_ctrl;
  logic [IDX_W-1:0]         out_idx;

  logic                     p1_valid, p2_valid, p3_valid, p4_valid, p5_valid, p6_valid;
  logic signed [ACC_W-1:0]  p1_acc [NUM_AXES];
  logic signed [ACC_W-1:0]  p2_acc [NUM_AXES];
  logic signed [ACC_W-1:0]  p3_acc [NUM_AXES];
  logic signed [RAD_W-1:0]  p2_r;
  logic signed [RAD_W-1:0]  p3_r;
  logic signed [PROD_W-1:0] p3_prod;
  logic signed [DIFF_W-1:0] p4_diff [NUM_AXES][NUM_COORDS];
  logic [SQ_W-1:0]          p5_sq [NUM_AXES][NUM_COORDS];
  logic [DIST_W-1:0]        p6_dist [NUM_CENTROIDS];

  logic signed [RAD_W-1:0]    diag;
  logic signed [2*DIFF_W-1:0] sq_full [NUM_AXES][NUM_COORDS];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_accel <= 16'sd4096;
      min_accel <= 16'sd4096;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_MAX_ACCEL: max_accel <= cfg_wdata;
        REG_MIN_ACCEL: min_accel <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Whole pipeline moves when the output slot is free or being taken
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
      p4_valid <= 1'b0;
      p5_valid <= 1'b0;
      p6_valid <= 1'b0;
    end else if (adv) begin
      p1_valid <= s_tvalid;
      p2_valid <= p1_valid;
      p3_valid <= p2_valid;
      p4_valid <= p3_valid;
      p5_valid <= p4_valid;
      p6_valid <= p5_valid;
    end
  end

  // Diagonal coordinate: floor of rounded product, Q3.13
  assign diag = p3_prod[RAD_W+15:16];

  // Full-width squares of the differences
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      for (int c = 0; c < NUM_COORDS; c++) begin
        sq_full[a][c] = p4_diff[a][c] * p4_diff[a][c];
      end
    end
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: capture sample
      p1_acc[0] <= s_tdata[15:0];
      p1_acc[1] <= s_tdata[31:16];
      p1_acc[2] <= s_tdata[47:32];
      // stage 2: radius in Q3.13
      p2_acc <= p1_acc;
      p2_r   <= RAD_W'(max_accel) + RAD_W'(min_accel);
      // stage 3: radius times cos 45 plus rounding half
      p3_acc  <= p2_acc;
      p3_r    <= p2_r;
      p3_prod <= PROD_W'(p2_r) * PROD_W'(COS45_Q16) + ROUND_HALF;
      // stage 4: sample (doubled to Q3.13) minus each coordinate value
      for (int a = 0; a < NUM_AXES; a++) begin
        p4_diff[a][AX_ZERO]  <= DIFF_W'($signed({p3_acc[a], 1'b0}));
        p4_diff[a][AX_POS_R] <= DIFF_W'($signed({p3_acc[a], 1'b0})) - DIFF_W'(p3_r);
        p4_diff[a][AX_NEG_R] <= DIFF_W'($signed({p3_acc[a], 1'b0})) + DIFF_W'(p3_r);
        p4_diff[a][AX_POS_D] <= DIFF_W'($signed({p3_acc[a], 1'b0})) - DIFF_W'(diag);
        p4_diff[a][AX_NEG_D] <= DIFF_W'($signed({p3_acc[a], 1'b0})) + DIFF_W'(diag);
      end
      // stage 5: squares
      for (int a = 0; a < NUM_AXES; a++) begin
        for (int c = 0; c < NUM_COORDS; c++) begin
          p5_sq[a][c] <= sq_full[a][c][SQ_W-1:0];
        end
      end
      // stage 6: squared distance to each centroid
      for (int k = 0; k < NUM_CENTROIDS; k++) begin
        p6_dist[k] <= DIST_W'(p5_sq[0][CENT_CODE[k][0]])
                    + DIST_W'(p5_sq[1][CENT_CODE[k][1]])
                    + DIST_W'(p5_sq[2][CENT_CODE[k][2]]);
      end
    end
  end

  assign tree_ctrl.adv   = adv;
  assign tree_ctrl.valid = p6_valid;

  ncq_argmin u_argmin (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (tree_ctrl),
    .dist_in   (p6_dist),
    .out_valid (m_tvalid),
    .out_idx   (out_idx)
  );

  assign m_tdata = {{(OUT_DATA_W-IDX_W){1'b0}}, out_idx};

  `NCQ_ASSERT_IMP(a_stall_blocks_input, clk, rst, m_tvalid && !m_tready, !s_tready,
    "input accepted while output stalled")
  `NCQ_ASSERT_IMP(a_index_in_range, clk, rst, m_tvalid,
    out_idx < IDX_W'(NUM_CENTROIDS), "centroid index out of range")
  `NCQ_ASSERT_NXT(a_accept_enters_pipe, clk, rst, s_tvalid && s_tready, p1_valid,
    "accepted beat did not enter the pipeline")
  `NCQ_ASSERT_NXT(a_stall_holds_tree, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(out_idx), "held result changed under stall")

endmodule
